// ----- src/cdh_pkg.sv -----
// ----------------------------------------------------------------------------
// cdh_pkg
// Shared types, constants and helpers of the coverage depth histogram unit.
// ----------------------------------------------------------------------------
package cdh_pkg;

  localparam int DEPTH_BINS  = 1024;
  localparam int BIN_W       = $clog2(DEPTH_BINS);
  localparam int NUM_MARKS   = 4;
  localparam int MIDX_W      = (NUM_MARKS > 1) ? $clog2(NUM_MARKS) : 1;
  localparam int NUM_RESULTS = 4 + NUM_MARKS;

  localparam int CNT_W   = 48;
  localparam int BIN_CW  = 32;
  localparam int BELOW_W = BIN_CW + BIN_W;
  localparam int CNT_IN_W = 16;
  localparam int DEPTH_W = CNT_IN_W + 1;
  localparam int THR_W   = 17;
  localparam int PROD_W  = THR_W + DEPTH_W;
  localparam int MARK_W  = 10;
  localparam int WIN_W   = 32;
  localparam int KIND_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_A    = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_COVERED      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READS_ALL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READS_TARGET = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BIASED       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MARK0        = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LAST         = KIND_W'(NUM_RESULTS - 1);

  // reset values
  localparam logic [CNT_IN_W-1:0] MIN_DEPTH_RST = 16'd10;
  localparam logic [THR_W-1:0]    THRESHOLD_RST = 17'd45875;
  localparam logic [MARK_W-1:0]   MARK_RST [4] = '{10'd1, 10'd20, 10'd100, 10'd500};

  typedef logic [MARK_W-1:0]  mark_t;
  typedef logic [BELOW_W-1:0] below_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_WALK,
    ST_EMIT
  } cdh_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] bases;
    logic [CNT_W-1:0] reads_all;
    logic [CNT_W-1:0] reads_target;
    logic [CNT_W-1:0] biased;
  } cdh_totals_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic [BIN_W-1:0] clamp_bin(input logic [DEPTH_W-1:0] v);
    return (int'(v) > DEPTH_BINS - 1) ? BIN_W'(DEPTH_BINS - 1) : BIN_W'(v);
  endfunction

endpackage

// ----- src/coverage_depth_histogram_unit.sv -----
// ----------------------------------------------------------------------------
// coverage_depth_histogram_unit
// Depth histogram with strand-bias count and coverage-at-depth report.
// ----------------------------------------------------------------------------
// Position sample: accept, bin read, bin write-back; no result.
// Report: walks the bin memory through one accumulator, then emits
//   4 + NUM_MARKS result words, one per cycle at best.
// The histogram memory's read-modify-write (one read, one write port) sets the sample rate.
// Reset: counters and control cleared, registers to defaults, then a
//   clearing pass over every bin of the histogram with in_ready low.
module coverage_depth_histogram_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [cdh_pkg::CNT_IN_W-1:0]      in_fwd_count,
  input  logic [cdh_pkg::CNT_IN_W-1:0]      in_rev_count,
  input  logic                              in_on_target,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cdh_pkg::KIND_W-1:0]        out_kind,
  output logic [cdh_pkg::CNT_W-1:0]         out_amount,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cdh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cdh_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [cdh_pkg::BIN_W-1:0]  BIN_TOP = cdh_pkg::BIN_W'(cdh_pkg::DEPTH_BINS - 1);
  localparam logic [cdh_pkg::BIN_CW-1:0] BIN_MAX = '1;

  cdh_pkg::cdh_state_t state_r, state_nxt;

  logic [cdh_pkg::BIN_W-1:0]    addr_r, addr_nxt;
  logic                         iss_done_r, iss_done_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [cdh_pkg::BIN_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [cdh_pkg::BIN_CW-1:0]   rd_data_r;

  logic [cdh_pkg::CNT_IN_W-1:0] fwd_r, fwd_nxt;
  logic [cdh_pkg::CNT_IN_W-1:0] rev_r, rev_nxt;
  logic                         ont_r, ont_nxt;
  logic [cdh_pkg::DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [cdh_pkg::PROD_W-1:0]   prod_r, prod_nxt;

  cdh_pkg::below_t              below_r, below_nxt;
  cdh_pkg::below_t              mark_sum_r [cdh_pkg::NUM_MARKS];
  cdh_pkg::below_t              mark_sum_nxt [cdh_pkg::NUM_MARKS];
  cdh_pkg::cdh_totals_t         totals_r, totals_nxt;
  logic [cdh_pkg::KIND_W-1:0]   emit_idx_r, emit_idx_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [cdh_pkg::KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [cdh_pkg::CNT_W-1:0]    out_amount_r, out_amount_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         ignore_r, ignore_nxt;
  logic [cdh_pkg::CNT_IN_W-1:0] min_depth_r, min_depth_nxt;
  logic [cdh_pkg::THR_W-1:0]    thr_r, thr_nxt;
  logic [cdh_pkg::WIN_W-1:0]    window_r, window_nxt;
  cdh_pkg::mark_t               mark_r [cdh_pkg::NUM_MARKS];
  cdh_pkg::mark_t               mark_nxt [cdh_pkg::NUM_MARKS];

  logic                         mem_we;
  logic [cdh_pkg::BIN_W-1:0]    mem_waddr;
  logic [cdh_pkg::BIN_CW-1:0]   mem_wdata;
  logic [cdh_pkg::BIN_W-1:0]    mem_raddr;
  logic [cdh_pkg::BIN_CW-1:0]   hist_mem [cdh_pkg::DEPTH_BINS];

  logic [cdh_pkg::BIN_W-1:0]    sample_bin;
  logic                         counted;
  logic                         biased;
  logic [cdh_pkg::CNT_W-1:0]    emit_amount;
  logic [cdh_pkg::DEPTH_W-1:0]  big;

  assign in_ready   = (state_r == cdh_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_amount = out_amount_r;
  assign out_last   = out_last_r;

  assign sample_bin = cdh_pkg::clamp_bin(depth_r);
  assign counted    = ignore_r | ont_r;
  assign big        = cdh_pkg::DEPTH_W'((fwd_r > rev_r) ? fwd_r : rev_r);
  assign biased     = (depth_r >= cdh_pkg::DEPTH_W'(min_depth_r)) &&
                      ({cdh_pkg::PROD_W'(big), 16'b0} > {16'b0, prod_r});

  cdh_amount u_amount (
    .kind             (emit_idx_r),
    .totals           (totals_r),
    .ignore_on_target (ignore_r),
    .window_bases     (window_r),
    .marks            (mark_r),
    .mark_sums        (mark_sum_r),
    .amount           (emit_amount)
  );

  // histogram memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= hist_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdh_pkg::ST_CLEAR;
      addr_r      <= '0;
      iss_done_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      totals_r    <= '0;
      out_valid_r <= 1'b0;
      emit_idx_r  <= '0;
      ignore_r    <= 1'b0;
      min_depth_r <= cdh_pkg::MIN_DEPTH_RST;
      thr_r       <= cdh_pkg::THRESHOLD_RST;
      window_r    <= '0;
      for (int k = 0; k < cdh_pkg::NUM_MARKS; k++) begin
        mark_r[k] <= cdh_pkg::MARK_RST[k];
      end
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      iss_done_r  <= iss_done_nxt;
      rd_vld_r    <= rd_vld_nxt;
      totals_r    <= totals_nxt;
      out_valid_r <= out_valid_nxt;
      emit_idx_r  <= emit_idx_nxt;
      ignore_r    <= ignore_nxt;
      min_depth_r <= min_depth_nxt;
      thr_r       <= thr_nxt;
      window_r    <= window_nxt;
      mark_r      <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    fwd_r        <= fwd_nxt;
    rev_r        <= rev_nxt;
    ont_r        <= ont_nxt;
    depth_r      <= depth_nxt;
    prod_r       <= prod_nxt;
    below_r      <= below_nxt;
    mark_sum_r   <= mark_sum_nxt;
    out_kind_r   <= out_kind_nxt;
    out_amount_r <= out_amount_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    iss_done_nxt   = iss_done_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = addr_r;
    fwd_nxt        = fwd_r;
    rev_nxt        = rev_r;
    ont_nxt        = ont_r;
    depth_nxt      = depth_r;
    prod_nxt       = prod_r;
    below_nxt      = below_r;
    mark_sum_nxt   = mark_sum_r;
    totals_nxt     = totals_r;
    emit_idx_nxt   = emit_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_amount_nxt = out_amount_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = '0;
    mem_raddr      = addr_r;

    case (state_r)
      cdh_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == BIN_TOP) begin
          state_nxt = cdh_pkg::ST_IDLE;
        end
      end
      cdh_pkg::ST_IDLE: begin
        if (in_valid) begin
          fwd_nxt   = in_fwd_count;
          rev_nxt   = in_rev_count;
          ont_nxt   = in_on_target;
          depth_nxt = cdh_pkg::DEPTH_W'(in_fwd_count) + cdh_pkg::DEPTH_W'(in_rev_count);
          if (in_mode) begin
            addr_nxt     = '0;
            iss_done_nxt = 1'b0;
            below_nxt    = '0;
            state_nxt    = cdh_pkg::ST_WALK;
          end else begin
            state_nxt = cdh_pkg::ST_READ;
          end
        end
      end
      cdh_pkg::ST_READ: begin
        mem_raddr = sample_bin;
        prod_nxt  = cdh_pkg::PROD_W'(thr_r) * cdh_pkg::PROD_W'(depth_r);
        state_nxt = cdh_pkg::ST_WRITE;
      end
      cdh_pkg::ST_WRITE: begin
        mem_waddr = sample_bin;
        mem_wdata = (rd_data_r == BIN_MAX) ? rd_data_r : rd_data_r + 1'b1;
        if (counted) begin
          mem_we           = 1'b1;
          totals_nxt.bases = cdh_pkg::sat_add(totals_r.bases, cdh_pkg::CNT_W'(1));
          if (biased) begin
            totals_nxt.biased = cdh_pkg::sat_add(totals_r.biased, cdh_pkg::CNT_W'(1));
          end
        end
        if (ont_r) begin
          totals_nxt.reads_target = cdh_pkg::sat_add(totals_r.reads_target,
                                                     cdh_pkg::CNT_W'(depth_r));
        end
        totals_nxt.reads_all = cdh_pkg::sat_add(totals_r.reads_all, cdh_pkg::CNT_W'(depth_r));
        state_nxt = cdh_pkg::ST_IDLE;
      end
      cdh_pkg::ST_WALK: begin
        // issue one bin read per cycle, accumulate the prefix sum behind it
        if (!iss_done_r) begin
          rd_vld_nxt = 1'b1;
          addr_nxt   = addr_r + 1'b1;
          if (addr_r == BIN_TOP) begin
            iss_done_nxt = 1'b1;
          end
        end
        if (rd_vld_r) begin
          for (int k = 0; k < cdh_pkg::NUM_MARKS; k++) begin
            if (rd_idx_r == cdh_pkg::clamp_bin(cdh_pkg::DEPTH_W'(mark_r[k]))) begin
              mark_sum_nxt[k] = below_r;
            end
          end
          below_nxt = below_r + cdh_pkg::BELOW_W'(rd_data_r);
          if (rd_idx_r == BIN_TOP) begin
            emit_idx_nxt = '0;
            state_nxt    = cdh_pkg::ST_EMIT;
          end
        end
      end
      cdh_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = emit_idx_r;
          out_amount_nxt = emit_amount;
          out_last_nxt   = (emit_idx_r == cdh_pkg::KIND_LAST);
          emit_idx_nxt   = emit_idx_r + 1'b1;
          if (emit_idx_r == cdh_pkg::KIND_LAST) begin
            state_nxt = cdh_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = cdh_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_comb begin
    ignore_nxt    = ignore_r;
    min_depth_nxt = min_depth_r;
    thr_nxt       = thr_r;
    window_nxt    = window_r;
    mark_nxt      = mark_r;
    if (cfg_valid) begin
      case (cfg_index)
        cdh_pkg::CFG_IGNORE:    ignore_nxt    = cfg_data[0];
        cdh_pkg::CFG_MIN_DEPTH: min_depth_nxt = cfg_data[cdh_pkg::CNT_IN_W-1:0];
        cdh_pkg::CFG_THRESHOLD: thr_nxt       = cfg_data[cdh_pkg::THR_W-1:0];
        cdh_pkg::CFG_WINDOW:    window_nxt    = cfg_data[cdh_pkg::WIN_W-1:0];
        default: begin
          for (int k = 0; k < cdh_pkg::NUM_MARKS; k++) begin
            if (cfg_index == cdh_pkg::CFG_IDX_W'(int'(cdh_pkg::CFG_MARK_A) + k)) begin
              mark_nxt[k] = cfg_data[cdh_pkg::MARK_W-1:0];
            end
          end
        end
      endcase
    end
  end

  a_last_on_final_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind == cdh_pkg::KIND_LAST)))
    else $error("last flag does not match final report word");

  a_walk_complete : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cdh_pkg::ST_WALK && state_nxt == cdh_pkg::ST_EMIT) |-> iss_done_r)
    else $error("report emitted before bin walk finished");

  a_bin_no_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cdh_pkg::ST_WRITE && mem_we) |-> (mem_wdata != '0))
    else $error("histogram bin wrapped");

  a_bases_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != cdh_pkg::ST_CLEAR) |=> (totals_r.bases >= $past(totals_r.bases)))
    else $error("covered base count decreased");

  a_no_emit_while_sampling : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cdh_pkg::ST_READ) |=> (state_r == cdh_pkg::ST_WRITE && !in_ready))
    else $error("sample read not followed by write-back");

endmodule

// ----- src/cdh_amount.sv -----
// ----------------------------------------------------------------------------
// cdh_amount
// Selects the value of one report word: a running total, the covered bases at
// a depth mark from the prefix sum of the bins below it, or for a zero mark the target.
// ----------------------------------------------------------------------------
module cdh_amount (
  input  logic [cdh_pkg::KIND_W-1:0] kind,
  input  cdh_pkg::cdh_totals_t       totals,
  input  logic                       ignore_on_target,
  input  logic [cdh_pkg::WIN_W-1:0]  window_bases,
  input  cdh_pkg::mark_t             marks [cdh_pkg::NUM_MARKS],
  input  cdh_pkg::below_t            mark_sums [cdh_pkg::NUM_MARKS],
  output logic [cdh_pkg::CNT_W-1:0]  amount
);

  logic [cdh_pkg::MIDX_W-1:0] midx;
  logic [cdh_pkg::CNT_W-1:0]  target;
  logic [cdh_pkg::CNT_W-1:0]  below;

  assign midx   = cdh_pkg::MIDX_W'(kind - cdh_pkg::KIND_MARK0);
  assign target = ignore_on_target ? cdh_pkg::CNT_W'(window_bases) : totals.bases;
  assign below  = cdh_pkg::CNT_W'(mark_sums[midx]);

  always_comb begin
    case (kind)
      cdh_pkg::KIND_COVERED:      amount = totals.bases;
      cdh_pkg::KIND_READS_ALL:    amount = totals.reads_all;
      cdh_pkg::KIND_READS_TARGET: amount = totals.reads_target;
      cdh_pkg::KIND_BIASED:       amount = totals.biased;
      default: begin
        if (marks[midx] == '0) begin
          amount = target;
        end else if (below >= totals.bases) begin
          amount = '0;
        end else begin
          amount = totals.bases - below;
        end
      end
    endcase
  end

endmodule

// ----- tb/sv/coverage_depth_histogram_unit_tb.sv -----
// ----------------------------------------------------------------------------
// coverage_depth_histogram_unit_tb
// Self-checking bench for the coverage depth histogram unit. Position samples
// and report requests go in through a valid/ready channel with random gaps.
// A shadow model predicts the histogram, totals and bias count, and every
// report word is checked against it in order. Register settings are changed
// between phases while the unit is idle.
// ----------------------------------------------------------------------------
module coverage_depth_histogram_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [cdh_pkg::KIND_W-1:0] kind;
    logic [cdh_pkg::CNT_W-1:0]  amount;
    logic                       last;
  } stat_word_t;

  typedef struct packed {
    logic                                           ignore;
    logic [cdh_pkg::CNT_IN_W-1:0]                   min_depth;
    logic [cdh_pkg::THR_W-1:0]                      threshold;
    logic [cdh_pkg::WIN_W-1:0]                      window;
    logic [cdh_pkg::NUM_MARKS-1:0][cdh_pkg::MARK_W-1:0] mark;
  } unit_cfg_t;

  localparam logic [cdh_pkg::CNT_W-1:0] CNT_MAX = {cdh_pkg::CNT_W{1'b1}};

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_mode;
  logic [cdh_pkg::CNT_IN_W-1:0]   in_fwd_count;
  logic [cdh_pkg::CNT_IN_W-1:0]   in_rev_count;
  logic                           in_on_target;
  logic                           out_valid;
  logic                           out_ready;
  logic [cdh_pkg::KIND_W-1:0]     out_kind;
  logic [cdh_pkg::CNT_W-1:0]      out_amount;
  logic                           out_last;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [cdh_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cdh_pkg::CFG_DATA_W-1:0] cfg_data;

  // shadow state
  logic [cdh_pkg::BIN_CW-1:0] bins_m [cdh_pkg::DEPTH_BINS];
  logic [cdh_pkg::CNT_W-1:0]  bases_m;
  logic [cdh_pkg::CNT_W-1:0]  reads_all_m;
  logic [cdh_pkg::CNT_W-1:0]  reads_tgt_m;
  logic [cdh_pkg::CNT_W-1:0]  biased_m;
  unit_cfg_t                  cfg_m;
  stat_word_t                 report_q [$];
  stat_word_t                 exp_w;

  int idle_pct  = 38;
  int stall_pct = 38;
  int errors;
  int samples;
  int reports;
  int words_checked;
  int cfg_loads;

  coverage_depth_histogram_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [cdh_pkg::CNT_W-1:0] add_sat(
      input logic [cdh_pkg::CNT_W-1:0] a,
      input logic [cdh_pkg::CNT_W-1:0] b);
    if (a > CNT_MAX - b) return CNT_MAX;
    return a + b;
  endfunction

  function automatic void absorb_sample(input logic [cdh_pkg::CNT_IN_W-1:0] fwd,
                                        input logic [cdh_pkg::CNT_IN_W-1:0] rev,
                                        input logic ont);
    logic [cdh_pkg::DEPTH_W-1:0]  depth;
    logic [cdh_pkg::CNT_IN_W-1:0] big;
    logic [63:0]                  lhs;
    logic [63:0]                  rhs;
    int                           bin;
    depth = cdh_pkg::DEPTH_W'(fwd) + cdh_pkg::DEPTH_W'(rev);
    if (cfg_m.ignore || ont) begin
      bin = (int'(depth) > cdh_pkg::DEPTH_BINS - 1) ? cdh_pkg::DEPTH_BINS - 1 : int'(depth);
      if (bins_m[bin] != {cdh_pkg::BIN_CW{1'b1}}) bins_m[bin] = bins_m[bin] + 1'b1;
      if (depth >= cdh_pkg::DEPTH_W'(cfg_m.min_depth)) begin
        big = (fwd > rev) ? fwd : rev;
        lhs = 64'(big) << 16;
        rhs = 64'(cfg_m.threshold) * 64'(depth);
        if (lhs > rhs) biased_m = add_sat(biased_m, cdh_pkg::CNT_W'(1));
      end
      bases_m = add_sat(bases_m, cdh_pkg::CNT_W'(1));
    end
    if (ont) reads_tgt_m = add_sat(reads_tgt_m, cdh_pkg::CNT_W'(depth));
    reads_all_m = add_sat(reads_all_m, cdh_pkg::CNT_W'(depth));
  endfunction

  function automatic logic [cdh_pkg::CNT_W-1:0] covered_at(input cdh_pkg::mark_t mark);
    logic [cdh_pkg::CNT_W-1:0] below;
    int                        top;
    if (mark == '0) return cfg_m.ignore ? cdh_pkg::CNT_W'(cfg_m.window) : bases_m;
    top = (int'(mark) > cdh_pkg::DEPTH_BINS - 1) ? cdh_pkg::DEPTH_BINS - 1 : int'(mark);
    below = '0;
    for (int i = 0; i < top; i++) below += cdh_pkg::CNT_W'(bins_m[i]);
    return (below >= bases_m) ? '0 : bases_m - below;
  endfunction

  function automatic void push_stat(input logic [cdh_pkg::KIND_W-1:0] kind,
                                    input logic [cdh_pkg::CNT_W-1:0] amount);
    report_q.push_back('{kind: kind, amount: amount,
                         last: (kind == cdh_pkg::KIND_LAST)});
  endfunction

  function automatic void queue_report();
    push_stat(cdh_pkg::KIND_COVERED, bases_m);
    push_stat(cdh_pkg::KIND_READS_ALL, reads_all_m);
    push_stat(cdh_pkg::KIND_READS_TARGET, reads_tgt_m);
    push_stat(cdh_pkg::KIND_BIASED, biased_m);
    for (int k = 0; k < cdh_pkg::NUM_MARKS; k++)
      push_stat(cdh_pkg::KIND_MARK0 + cdh_pkg::KIND_W'(k), covered_at(cfg_m.mark[k]));
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        $error("unexpected word: kind %0d amount %0d last %0d",
               out_kind, out_amount, out_last);
        errors++;
      end else begin
        exp_w = report_q.pop_front();
        if (out_kind !== exp_w.kind) begin
          $error("kind: expected %0d, actual %0d", exp_w.kind, out_kind);
          errors++;
        end
        if (out_amount !== exp_w.amount) begin
          $error("amount: expected %0d, actual %0d", exp_w.amount, out_amount);
          errors++;
        end
        if (out_last !== exp_w.last) begin
          $error("last: expected %0d, actual %0d", exp_w.last, out_last);
          errors++;
        end
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(input logic mode, input logic [cdh_pkg::CNT_IN_W-1:0] fwd,
                           input logic [cdh_pkg::CNT_IN_W-1:0] rev, input logic ont);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_fwd_count <= fwd;
    in_rev_count <= rev;
    in_on_target <= ont;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (mode) begin
      queue_report();
      reports++;
    end else begin
      absorb_sample(fwd, rev, ont);
      samples++;
    end
  endtask

  task automatic sample(input logic [cdh_pkg::CNT_IN_W-1:0] fwd,
                        input logic [cdh_pkg::CNT_IN_W-1:0] rev, input logic ont);
    send_word(1'b0, fwd, rev, ont);
  endtask

  task automatic report();
    send_word(1'b1, cdh_pkg::CNT_IN_W'($urandom), cdh_pkg::CNT_IN_W'($urandom),
              1'($urandom));
  endtask

  task automatic write_reg(input logic [cdh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cdh_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(input unit_cfg_t c);
    write_reg(cdh_pkg::CFG_IGNORE, cdh_pkg::CFG_DATA_W'(c.ignore));
    write_reg(cdh_pkg::CFG_MIN_DEPTH, cdh_pkg::CFG_DATA_W'(c.min_depth));
    write_reg(cdh_pkg::CFG_THRESHOLD, cdh_pkg::CFG_DATA_W'(c.threshold));
    write_reg(cdh_pkg::CFG_WINDOW, cdh_pkg::CFG_DATA_W'(c.window));
    for (int k = 0; k < cdh_pkg::NUM_MARKS; k++)
      write_reg(cdh_pkg::CFG_MARK_A + cdh_pkg::CFG_IDX_W'(k),
                cdh_pkg::CFG_DATA_W'(c.mark[k]));
    cfg_valid <= 1'b0;
    cfg_m = c;
    cfg_loads++;
  endtask

  // wait until all report words are back and the last sample has landed
  task automatic quiesce();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    report();
    sample(16'd0, 16'd0, 1'b1);
    sample(16'hFFFF, 16'hFFFF, 1'b1);
    sample(16'hFFFF, 16'd0, 1'b1);
    sample(16'd9, 16'd0, 1'b1);
    sample(16'd10, 16'd0, 1'b1);
    sample(16'd300, 16'd700, 1'b0);
    report();
    quiesce();
  endtask

  task automatic test_bias_boundary();
    unit_cfg_t c;
    c = '{ignore: 1'b0, min_depth: 16'd1, threshold: 17'd32768, window: '0,
          mark: '{10'd2, 10'd1, 10'd1023, 10'd0}};
    load_config(c);
    sample(16'd7, 16'd7, 1'b1);
    sample(16'd8, 16'd7, 1'b1);
    sample(16'd512, 16'd511, 1'b1);
    sample(16'd511, 16'd511, 1'b1);
    sample(16'd600, 16'd424, 1'b1);
    sample(16'd1, 16'd0, 1'b1);
    report();
    quiesce();
  endtask

  task automatic test_ignore_mode();
    unit_cfg_t c;
    c = '{ignore: 1'b1, min_depth: 16'd0, threshold: 17'd65536, window: '1,
          mark: '{10'd20, 10'd500, 10'd1023, 10'd0}};
    load_config(c);
    sample(16'd0, 16'd0, 1'b0);
    sample(16'd40000, 16'd0, 1'b0);
    sample(16'd3, 16'd2, 1'b1);
    report();
    quiesce();
    c.min_depth = 16'hFFFF;
    c.threshold = '0;
    c.window    = '0;
    load_config(c);
    sample(16'hFFFF, 16'd0, 1'b0);
    sample(16'd0, 16'd1, 1'b0);
    report();
    quiesce();
  endtask

  function automatic logic [cdh_pkg::CNT_IN_W-1:0] rand_count();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return cdh_pkg::CNT_IN_W'($urandom_range(0, 600));
    if (pick < 85) return cdh_pkg::CNT_IN_W'($urandom_range(0, 2000));
    return cdh_pkg::CNT_IN_W'($urandom);
  endfunction

  function automatic unit_cfg_t rand_config();
    unit_cfg_t c;
    int        pick;
    c.ignore = 1'($urandom_range(1));
    pick = $urandom_range(3);
    c.min_depth = (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF :
                  (pick == 2) ? cdh_pkg::CNT_IN_W'($urandom_range(1, 64)) :
                  cdh_pkg::CNT_IN_W'($urandom);
    pick = $urandom_range(3);
    c.threshold = (pick == 0) ? 17'd0 : (pick == 1) ? 17'd65536 :
                  (pick == 2) ? cdh_pkg::THR_W'($urandom_range(0, 65536)) :
                  cdh_pkg::THR_W'($urandom_range(32768, 52000));
    pick = $urandom_range(2);
    c.window = (pick == 0) ? '0 : (pick == 1) ? '1 : cdh_pkg::WIN_W'($urandom);
    for (int k = 0; k < cdh_pkg::NUM_MARKS; k++) begin
      pick = $urandom_range(9);
      c.mark[k] = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023 :
                  cdh_pkg::MARK_W'($urandom_range(0, 1023));
    end
    return c;
  endfunction

  task automatic test_random_phases();
    logic [cdh_pkg::CNT_IN_W-1:0] fwd;
    logic [cdh_pkg::CNT_IN_W-1:0] rev;
    for (int phase = 0; phase < 6; phase++) begin
      load_config(rand_config());
      if (phase == 3) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 38;
        stall_pct = 38;
      end
      for (int n = 0; n < 37; n++) begin
        if ($urandom_range(99) < 10) begin
          report();
        end else begin
          fwd = rand_count();
          rev = rand_count();
          if ($urandom_range(2) == 0) rev = rev >> $urandom_range(1, 8);
          sample(fwd, rev, 1'($urandom_range(99) < 70));
        end
      end
      report();
      quiesce();
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_mode      <= 1'b0;
    in_fwd_count <= '0;
    in_rev_count <= '0;
    in_on_target <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    for (int i = 0; i < cdh_pkg::DEPTH_BINS; i++) bins_m[i] = '0;
    bases_m     = '0;
    reads_all_m = '0;
    reads_tgt_m = '0;
    biased_m    = '0;
    cfg_m = '{ignore: 1'b0, min_depth: cdh_pkg::MIN_DEPTH_RST,
              threshold: cdh_pkg::THRESHOLD_RST, window: '0,
              mark: '{cdh_pkg::MARK_RST[3], cdh_pkg::MARK_RST[2],
                      cdh_pkg::MARK_RST[1], cdh_pkg::MARK_RST[0]}};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_bias_boundary();
    test_ignore_mode();
    test_random_phases();

    quiesce();
    repeat (16) @(posedge clk);
    $display("Run covered %0d position samples and %0d report requests, %0d words checked.",
             samples, reports, words_checked);
    $display("%0d register settings applied, extremes of marks, threshold and window included.",
             cfg_loads);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
